// ===== hw/rtl/dsq_pkg.sv =====
// Shared types, constants and control/status bundles for the delta sleep queue.
// No dependencies; used by dsq_ctrl, dsq_dpath and delta_sleep_queue.
package dsq_pkg;

	localparam int MAX_SLEEPERS = 16;
	localparam int ID_BITS      = 8;
	localparam int DELTA_BITS   = 31;
	localparam int TIME_BITS    = 32;
	localparam int CNT_BITS     = $clog2(MAX_SLEEPERS + 1);
	localparam int IDX_BITS     = $clog2(MAX_SLEEPERS);

	typedef logic [DELTA_BITS-1:0] delta_t;
	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [TIME_BITS-1:0]  time_t;

	localparam logic CMD_INSERT   = 1'b0;
	localparam logic CMD_TICK     = 1'b1;
	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_NEG  = 2'd1,
		STS_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_INS_OUT,
		S_TICK,
		S_REL
	} fsm_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_in;
		logic    scan_step;
		logic    place;
		logic    tick_dec;
		logic    pop;
		logic    out_load;
		logic    out_kind;
		status_t out_status;
		logic    out_last;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic t_neg;
		logic t_zero;
		logic full;
		logic cnt_zero;
		logic scan_end;
		logic scan_hit;
		logic head_le1;
		logic rel_last;
		logic out_free;
	} stat_t;

endpackage

// ===== hw/rtl/dsq_ctrl.sv =====
// Sequencer for the delta sleep queue: insert scan/place and tick release.
// Depends on dsq_pkg; drives dsq_dpath through dsq_pkg::ctrl_t.
module dsq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           cmd,
	input  dsq_pkg::stat_t stat,
	output dsq_pkg::ctrl_t ctl,
	output logic           in_stall
);

	dsq_pkg::fsm_t    state_q, state_d;
	dsq_pkg::status_t ins_status_q, ins_status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dsq_pkg::S_IDLE;
			ins_status_q <= dsq_pkg::STS_OK;
		end else begin
			state_q      <= state_d;
			ins_status_q <= ins_status_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsq_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == dsq_pkg::CMD_TICK) ? dsq_pkg::S_TICK : dsq_pkg::S_SCAN;
				end
			end
			dsq_pkg::S_SCAN: begin
				if (stat.t_neg || stat.t_zero || stat.full) begin
					state_d = dsq_pkg::S_INS_OUT;
				end else if (stat.scan_end || stat.scan_hit) begin
					state_d = dsq_pkg::S_PLACE;
				end
			end
			dsq_pkg::S_PLACE: state_d = dsq_pkg::S_INS_OUT;
			dsq_pkg::S_INS_OUT: begin
				if (stat.out_free) state_d = dsq_pkg::S_IDLE;
			end
			dsq_pkg::S_TICK: begin
				if (stat.cnt_zero || !stat.head_le1) state_d = dsq_pkg::S_IDLE;
				else state_d = dsq_pkg::S_REL;
			end
			dsq_pkg::S_REL: begin
				if (stat.out_free && stat.rel_last) state_d = dsq_pkg::S_IDLE;
			end
			default: state_d = dsq_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl          = '0;
		ins_status_d = ins_status_q;
		in_stall     = 1'b1;
		unique case (state_q)
			dsq_pkg::S_IDLE: begin
				in_stall    = 1'b0;
				ctl.load_in = in_valid;
			end
			dsq_pkg::S_SCAN: begin
				if (stat.t_neg) begin
					ins_status_d = dsq_pkg::STS_NEG;
				end else if (stat.t_zero) begin
					ins_status_d = dsq_pkg::STS_OK;
				end else if (stat.full) begin
					ins_status_d = dsq_pkg::STS_FULL;
				end else if (!(stat.scan_end || stat.scan_hit)) begin
					ctl.scan_step = 1'b1;
				end
			end
			dsq_pkg::S_PLACE: begin
				ctl.place    = 1'b1;
				ins_status_d = dsq_pkg::STS_OK;
			end
			dsq_pkg::S_INS_OUT: begin
				ctl.out_load   = stat.out_free;
				ctl.out_kind   = dsq_pkg::KIND_INSERT;
				ctl.out_status = ins_status_q;
				ctl.out_last   = 1'b1;
			end
			dsq_pkg::S_TICK: begin
				ctl.tick_dec = !stat.cnt_zero;
			end
			dsq_pkg::S_REL: begin
				ctl.out_load   = stat.out_free;
				ctl.pop        = stat.out_free;
				ctl.out_kind   = dsq_pkg::KIND_RELEASE;
				ctl.out_status = dsq_pkg::STS_OK;
				ctl.out_last   = stat.rel_last;
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/dsq_dpath.sv =====
// Queue storage, scan arithmetic and output register for the delta sleep queue.
// Depends on dsq_pkg; commanded by dsq_ctrl.
module dsq_dpath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dsq_pkg::ctrl_t         ctl,
	output dsq_pkg::stat_t         stat,
	input  logic [7:0]             thread_id,
	input  logic signed [31:0]     nap_ticks,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic                   kind,
	output logic [1:0]             status,
	output logic [7:0]             released_id,
	output logic                   last
);

	dsq_pkg::delta_t delta_q [dsq_pkg::MAX_SLEEPERS];
	dsq_pkg::id_t    id_q    [dsq_pkg::MAX_SLEEPERS];
	dsq_pkg::cnt_t   count_q;
	dsq_pkg::cnt_t   idx_q;
	dsq_pkg::time_t  t_q;
	dsq_pkg::id_t    nid_q;

	logic             out_valid_q;
	logic             kind_q;
	dsq_pkg::status_t status_q;
	dsq_pkg::id_t     rid_q;
	logic             last_q;

	dsq_pkg::delta_t cur_delta;
	dsq_pkg::delta_t t_low;
	dsq_pkg::delta_t split;
	dsq_pkg::cnt_t   pos_next;

	assign cur_delta = delta_q[idx_q[dsq_pkg::IDX_BITS-1:0]];
	assign t_low     = t_q[dsq_pkg::DELTA_BITS-1:0];
	assign split     = cur_delta - t_low;
	assign pos_next  = idx_q + dsq_pkg::cnt_t'(1);

	always_comb begin
		stat.t_neg    = t_q[dsq_pkg::TIME_BITS-1];
		stat.t_zero   = (t_q == '0);
		stat.full     = (count_q == dsq_pkg::cnt_t'(dsq_pkg::MAX_SLEEPERS));
		stat.cnt_zero = (count_q == '0);
		stat.scan_end = (idx_q == count_q);
		stat.scan_hit = (t_low <= cur_delta);
		stat.head_le1 = (delta_q[0] <= dsq_pkg::delta_t'(1));
		stat.rel_last = (count_q == dsq_pkg::cnt_t'(1)) || (delta_q[1] != '0);
		stat.out_free = !out_valid_q || !out_stall;
	end

	// control registers: fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.load_in) idx_q <= '0;
			else if (ctl.scan_step) idx_q <= pos_next;
			if (ctl.place) count_q <= count_q + dsq_pkg::cnt_t'(1);
			else if (ctl.pop) count_q <= count_q - dsq_pkg::cnt_t'(1);
		end
	end

	// request latch and remaining time
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			t_q   <= dsq_pkg::time_t'(nap_ticks);
			nid_q <= dsq_pkg::id_t'(thread_id);
		end else if (ctl.scan_step) begin
			t_q <= {1'b0, t_low - cur_delta};
		end
	end

	// queue storage: place shifts the tail up, pop shifts everything down
	always_ff @(posedge clk) begin
		if (ctl.place) begin
			if (idx_q == '0) begin
				delta_q[0] <= t_low;
				id_q[0]    <= nid_q;
			end
			for (int i = 1; i < dsq_pkg::MAX_SLEEPERS; i++) begin
				if (dsq_pkg::cnt_t'(i) == idx_q) begin
					delta_q[i] <= t_low;
					id_q[i]    <= nid_q;
				end else if (dsq_pkg::cnt_t'(i) == pos_next) begin
					delta_q[i] <= split;
					id_q[i]    <= id_q[i-1];
				end else if (dsq_pkg::cnt_t'(i) > pos_next) begin
					delta_q[i] <= delta_q[i-1];
					id_q[i]    <= id_q[i-1];
				end
			end
		end else if (ctl.pop) begin
			for (int i = 0; i < dsq_pkg::MAX_SLEEPERS - 1; i++) begin
				delta_q[i] <= delta_q[i+1];
				id_q[i]    <= id_q[i+1];
			end
		end else if (ctl.tick_dec) begin
			if (delta_q[0] != '0) delta_q[0] <= delta_q[0] - dsq_pkg::delta_t'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			kind_q   <= ctl.out_kind;
			status_q <= ctl.out_status;
			rid_q    <= (ctl.out_kind == dsq_pkg::KIND_RELEASE) ? id_q[0] : '0;
			last_q   <= ctl.out_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status      = status_q;
	assign released_id = 8'(rid_q);
	assign last        = last_q;

endmodule

// ===== hw/rtl/delta_sleep_queue.sv =====
// Delta sleep queue top level: sequencer plus storage datapath.
// Depends on dsq_pkg, dsq_ctrl and dsq_dpath.
// Insert: an insert rejected (negative time, full) or not queued (zero time)
//   is decided in S_SCAN and its result loaded in S_INS_OUT; a queued insert
//   walks the entries in S_SCAN (one compare/subtract per entry), then S_PLACE, S_INS_OUT.
// Tick: S_TICK lowers the head delta, then one released beat per cycle
//   while the output is not stalled. One item is in flight at a time; the next
//   is accepted the cycle after its predecessor's last result is registered.
// Reset: fill count cleared (queue empty); entry storage is not cleared.
module delta_sleep_queue (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         thread_id,
	input  logic signed [31:0] nap_ticks,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [1:0]         status,
	output logic [7:0]         released_id,
	output logic               last
);

	dsq_pkg::ctrl_t ctl;
	dsq_pkg::stat_t stat;

	// Controller walks the queue one entry per cycle on insert and pops one
	// released thread per cycle on tick while the output is not stalled; all queue storage lives in the datapath.
	dsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl),
		.in_stall (in_stall)
	);

	// Datapath holds deltas, ids, fill count, the remaining-time register and
	// the output beat register, so a finished beat can wait under stall.
	dsq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.thread_id   (thread_id),
		.nap_ticks   (nap_ticks),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.status      (status),
		.released_id (released_id),
		.last        (last)
	);

	// a new beat never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> stat.out_free)
		else $error("output beat loaded while previous beat stalled");

	// a release never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !stat.cnt_zero)
		else $error("pop on empty queue");

	// placement only for a positive time into a queue with room
	a_place_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.place |-> (!stat.full && !stat.t_neg && !stat.t_zero))
		else $error("illegal placement");

endmodule
